@@ rtl/core/dhfk_pkg.sv @@
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared widths, link constants and small tables for the arm kinematics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dhfk_pkg;

  localparam int AngW      = 16;
  localparam int ThW       = 22;
  localparam int CsW       = 20;
  localparam int PosW      = 24;
  localparam int ProdW     = 48;
  localparam int OutW      = 20;
  localparam int Lanes     = 3;
  localparam int Steps     = 16;
  localparam int XformLat  = 7;
  localparam int Latency   = 1 + Steps + XformLat;

  localparam logic signed [ThW-1:0] PiQ      = 22'sd205887;
  localparam logic signed [ThW-1:0] TwoPiQ   = 22'sd411775;
  localparam logic signed [ThW-1:0] HalfPiQ  = 22'sd102944;
  localparam logic signed [CsW-1:0] GainQ    = 20'sd39797;

  localparam logic signed [PosW-1:0] LinkA1  = 24'sd18566;
  localparam logic signed [PosW-1:0] LinkA2  = 24'sd10971;
  localparam logic signed [PosW-1:0] BaseTx  = -24'sd6184;
  localparam logic signed [PosW-1:0] BaseTy  = 24'sd40;
  localparam logic signed [PosW-1:0] BaseTz  = -24'sd4138;
  localparam logic signed [OutW-1:0] OutMax  = 20'sd524287;
  localparam logic signed [OutW-1:0] OutMin  = -20'sd524288;

  function automatic logic signed [CsW-1:0] atan_q(input int idx);
    logic signed [CsW-1:0] v;
    case (idx)
      0: v = 20'sd51472;
      1: v = 20'sd30386;
      2: v = 20'sd16055;
      3: v = 20'sd8150;
      4: v = 20'sd4091;
      5: v = 20'sd2047;
      6: v = 20'sd1024;
      7: v = 20'sd512;
      8: v = 20'sd256;
      9: v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ThW-1:0] theta_off(input logic side, input int lane);
    logic signed [ThW-1:0] v;
    case (lane)
      0: v = side ? -22'sd102944 : 22'sd102944;
      1: v = side ? 22'sd0 : 22'sd205888;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [PosW-1:0] rnd_q16(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] t;
    t = (v + 48'sd32768) >>> 16;
    return t[PosW-1:0];
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [PosW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > PosW'(OutMax)) begin
      r = OutMax;
    end else if (v < PosW'(OutMin)) begin
      r = OutMin;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dhfk_prep.sv @@
// ----------------------------------------------------------------------------
// dhfk_prep
// Adds the joint offset and folds one angle into the rotator's range.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfk_prep #(
  parameter int LANE = 0
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic                                side,
  input  wire logic signed [dhfk_pkg::AngW-1:0]    angle,
  output logic signed [dhfk_pkg::CsW-1:0]          z_r,
  output logic                                     neg_r
);

  logic signed [dhfk_pkg::ThW-1:0] t0, t1, t2;
  logic signed [dhfk_pkg::CsW-1:0] z_nxt;
  logic                            neg_nxt;

  always_comb begin
    t0 = (dhfk_pkg::ThW'(angle) <<< 4) + dhfk_pkg::theta_off(side, LANE);
    t1 = t0;
    if (t1 > dhfk_pkg::PiQ) begin
      t1 = t1 - dhfk_pkg::TwoPiQ;
    end
    if (t1 > dhfk_pkg::PiQ) begin
      t1 = t1 - dhfk_pkg::TwoPiQ;
    end
    if (t1 < -dhfk_pkg::PiQ) begin
      t1 = t1 + dhfk_pkg::TwoPiQ;
    end
    if (t1 < -dhfk_pkg::PiQ) begin
      t1 = t1 + dhfk_pkg::TwoPiQ;
    end
    t2      = t1;
    neg_nxt = 1'b0;
    if (t1 > dhfk_pkg::HalfPiQ) begin
      t2      = t1 - dhfk_pkg::PiQ;
      neg_nxt = 1'b1;
    end else if (t1 < -dhfk_pkg::HalfPiQ) begin
      t2      = t1 + dhfk_pkg::PiQ;
      neg_nxt = 1'b1;
    end
    z_nxt = t2[dhfk_pkg::CsW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r   <= z_nxt;
      neg_r <= neg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dhfk_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// dhfk_cordic_cell
// One rotation step of the sine and cosine chain for one joint.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfk_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [dhfk_pkg::CsW-1:0]   x_in,
  input  wire logic signed [dhfk_pkg::CsW-1:0]   y_in,
  input  wire logic signed [dhfk_pkg::CsW-1:0]   z_in,
  input  wire logic                              neg_in,
  output logic signed [dhfk_pkg::CsW-1:0]        x_r,
  output logic signed [dhfk_pkg::CsW-1:0]        y_r,
  output logic signed [dhfk_pkg::CsW-1:0]        z_r,
  output logic                                   neg_r
);

  logic signed [dhfk_pkg::CsW-1:0] dx, dy, x_nxt, y_nxt, z_nxt;

  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    if (!z_in[dhfk_pkg::CsW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - dhfk_pkg::atan_q(STEP);
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + dhfk_pkg::atan_q(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      neg_r <= neg_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dhfk_xform.sv @@
// ----------------------------------------------------------------------------
// dhfk_xform
// Chains the three joint transforms and the base transform over seven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfk_xform (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic                              side,
  input  wire logic signed [dhfk_pkg::CsW-1:0]   cx [dhfk_pkg::Lanes],
  input  wire logic signed [dhfk_pkg::CsW-1:0]   sy [dhfk_pkg::Lanes],
  input  wire logic                              neg [dhfk_pkg::Lanes],
  output logic signed [dhfk_pkg::OutW-1:0]       x_pos_r,
  output logic signed [dhfk_pkg::OutW-1:0]       y_pos_r,
  output logic signed [dhfk_pkg::OutW-1:0]       z_pos_r
);

  localparam int CW = dhfk_pkg::CsW;
  localparam int PW = dhfk_pkg::PosW;
  localparam int MW = dhfk_pkg::ProdW;

  logic signed [CW-1:0] c [dhfk_pkg::Lanes];
  logic signed [CW-1:0] s [dhfk_pkg::Lanes];

  logic signed [MW-1:0] m_ac3_r, m_as3_r;
  logic signed [CW-1:0] c1a_r, s1a_r, c2a_r, s2a_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [CW-1:0] c1b_r, s1b_r, c2b_r, s2b_r;
  logic signed [MW-1:0] m_cp0_r, m_sp1_r, m_sp0_r, m_cp1_r, m_ac2_r, m_as2_r;
  logic signed [PW-1:0] p2c_r;
  logic signed [CW-1:0] c1c_r, s1c_r;
  logic signed [PW-1:0] q0_r, q1_r, q2_r;
  logic signed [CW-1:0] c1d_r, s1d_r;
  logic signed [MW-1:0] m_cq0_r, m_sq2_r, m_sq0_r, m_cq2_r;
  logic signed [PW-1:0] q1e_r;
  logic signed [PW-1:0] r0_r, r1_r, r2_r;
  logic signed [PW-1:0] bx, by, bz;

  always_comb begin
    for (int l = 0; l < dhfk_pkg::Lanes; l++) begin
      c[l] = neg[l] ? -cx[l] : cx[l];
      s[l] = neg[l] ? -sy[l] : sy[l];
    end
    if (side) begin
      bx = r2_r + dhfk_pkg::BaseTx;
      by = r0_r + dhfk_pkg::BaseTy;
    end else begin
      bx = -r2_r + dhfk_pkg::BaseTx;
      by = -r0_r - dhfk_pkg::BaseTy;
    end
    bz = r1_r + dhfk_pkg::BaseTz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ac3_r <= dhfk_pkg::LinkA2 * c[2];
      m_as3_r <= dhfk_pkg::LinkA2 * s[2];
      c1a_r   <= c[0];
      s1a_r   <= s[0];
      c2a_r   <= c[1];
      s2a_r   <= s[1];

      p0_r    <= dhfk_pkg::rnd_q16(m_ac3_r);
      p1_r    <= dhfk_pkg::rnd_q16(m_as3_r);
      p2_r    <= side ? -24'sd7465 : 24'sd7465;
      c1b_r   <= c1a_r;
      s1b_r   <= s1a_r;
      c2b_r   <= c2a_r;
      s2b_r   <= s2a_r;

      m_cp0_r <= c2b_r * p0_r;
      m_sp1_r <= s2b_r * p1_r;
      m_sp0_r <= s2b_r * p0_r;
      m_cp1_r <= c2b_r * p1_r;
      m_ac2_r <= dhfk_pkg::LinkA1 * c2b_r;
      m_as2_r <= dhfk_pkg::LinkA1 * s2b_r;
      p2c_r   <= p2_r;
      c1c_r   <= c1b_r;
      s1c_r   <= s1b_r;

      q0_r    <= dhfk_pkg::rnd_q16(m_cp0_r - m_sp1_r) + dhfk_pkg::rnd_q16(m_ac2_r);
      q1_r    <= dhfk_pkg::rnd_q16(m_sp0_r + m_cp1_r) + dhfk_pkg::rnd_q16(m_as2_r);
      q2_r    <= p2c_r;
      c1d_r   <= c1c_r;
      s1d_r   <= s1c_r;

      m_cq0_r <= c1d_r * q0_r;
      m_sq2_r <= s1d_r * q2_r;
      m_sq0_r <= s1d_r * q0_r;
      m_cq2_r <= c1d_r * q2_r;
      q1e_r   <= q1_r;

      r0_r    <= dhfk_pkg::rnd_q16(m_cq0_r + m_sq2_r);
      r1_r    <= dhfk_pkg::rnd_q16(m_sq0_r - m_cq2_r);
      r2_r    <= q1e_r + (side ? 24'sd6731 : -24'sd6731);

      x_pos_r <= dhfk_pkg::sat_out(bx);
      y_pos_r <= dhfk_pkg::sat_out(by);
      z_pos_r <= dhfk_pkg::sat_out(bz);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dh_forward_kinematics_3dof_unit.sv @@
// ----------------------------------------------------------------------------
// One item is accepted per cycle; the rotator cell chain and the seven
// transform stages all advance together and stop only while the result stalls.
// Reset clears the pipeline valid bits and selects arm side 0.
// ----------------------------------------------------------------------------
// dh_forward_kinematics_3dof_unit
// Three-joint arm position from joint angles through a pipelined cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dh_forward_kinematics_3dof_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  in_first_angle,
  input  wire logic signed [15:0]  in_second_angle,
  input  wire logic signed [15:0]  in_third_angle,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [19:0]       out_x_pos,
  output logic signed [19:0]       out_y_pos,
  output logic signed [19:0]       out_z_pos
);

  localparam int N  = dhfk_pkg::Latency;
  localparam int CW = dhfk_pkg::CsW;

  logic         arm_side_r, arm_side_nxt;
  logic [N-1:0] vld_r, vld_nxt;
  logic         adv;

  logic signed [dhfk_pkg::AngW-1:0] ang [dhfk_pkg::Lanes];
  logic signed [CW-1:0] xc [dhfk_pkg::Steps+1][dhfk_pkg::Lanes];
  logic signed [CW-1:0] yc [dhfk_pkg::Steps+1][dhfk_pkg::Lanes];
  logic signed [CW-1:0] zc [dhfk_pkg::Steps+1][dhfk_pkg::Lanes];
  logic                 nc [dhfk_pkg::Steps+1][dhfk_pkg::Lanes];

  assign adv       = !vld_r[N-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[N-1];

  assign ang[0] = in_first_angle;
  assign ang[1] = in_second_angle;
  assign ang[2] = in_third_angle;

  always_comb begin
    arm_side_nxt = cfg_we ? cfg_wdata : arm_side_r;
    vld_nxt      = adv ? {vld_r[N-2:0], in_valid} : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_side_r <= 1'b0;
      vld_r      <= '0;
    end else begin
      arm_side_r <= arm_side_nxt;
      vld_r      <= vld_nxt;
    end
  end

  for (genvar l = 0; l < dhfk_pkg::Lanes; l++) begin : g_lane
    assign xc[0][l] = dhfk_pkg::GainQ;
    assign yc[0][l] = '0;

    dhfk_prep #(.LANE(l)) u_prep (
      .clk   (clk),
      .en    (adv),
      .side  (arm_side_r),
      .angle (ang[l]),
      .z_r   (zc[0][l]),
      .neg_r (nc[0][l])
    );

    for (genvar k = 0; k < dhfk_pkg::Steps; k++) begin : g_step
      dhfk_cordic_cell #(.STEP(k)) u_cell (
        .clk    (clk),
        .en     (adv),
        .x_in   (xc[k][l]),
        .y_in   (yc[k][l]),
        .z_in   (zc[k][l]),
        .neg_in (nc[k][l]),
        .x_r    (xc[k+1][l]),
        .y_r    (yc[k+1][l]),
        .z_r    (zc[k+1][l]),
        .neg_r  (nc[k+1][l])
      );
    end
  end

  dhfk_xform u_xform (
    .clk     (clk),
    .en      (adv),
    .side    (arm_side_r),
    .cx      (xc[dhfk_pkg::Steps]),
    .sy      (yc[dhfk_pkg::Steps]),
    .neg     (nc[dhfk_pkg::Steps]),
    .x_pos_r (out_x_pos),
    .y_pos_r (out_y_pos),
    .z_pos_r (out_z_pos)
  );

endmodule

`default_nettype wire

@@ dv/dh_forward_kinematics_3dof_unit_test.sv @@
// ----------------------------------------------------------------------------
// Arm kinematics unit testbench
// Drives joint-angle sets through the unit, predicts each end-effector
// position with a fixed-point kinematics model, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dh_forward_kinematics_3dof_unit_test;

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } position_t;

  class position_scoreboard;
    position_t pending[$];
    int errors;
    bit arm_side;

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint rnd(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function void sin_cos(longint theta, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit neg;
      longint atan_tab[16];
      atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
      x = 39797;
      y = 0;
      neg = 0;
      while (theta > 205887) theta -= 411775;
      while (theta < -205887) theta += 411775;
      if (theta > 102944) begin
        theta -= 205887;
        neg = 1;
      end else if (theta < -102944) begin
        theta += 205887;
        neg = 1;
      end
      z = theta;
      for (int i = 0; i < 16; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function void transform(longint r[3][3], longint t[3], ref longint p[3]);
      longint n[3];
      for (int k = 0; k < 3; k++)
        n[k] = rnd(r[k][0] * p[0] + r[k][1] * p[1] + r[k][2] * p[2]) + t[k];
      p = n;
    endfunction

    function logic signed [19:0] clamp(longint v);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v[19:0];
    endfunction

    function void note_angles(logic signed [15:0] a1, logic signed [15:0] a2,
                              logic signed [15:0] a3);
      longint p[3], r[3][3], t[3], ang[3], la[3], ld[3], lca[3], lsa[3], loff[3];
      longint ct, st;
      position_t e;
      ang = '{a1, a2, a3};
      la = '{0, 18566, 10971};
      if (!arm_side) begin
        ld = '{-6731, 0, 7465};
        loff = '{102944, 205888, 0};
      end else begin
        ld = '{6731, 0, -7465};
        loff = '{-102944, 0, 0};
      end
      lca = '{0, 65536, 65536};
      lsa = '{65536, 0, 0};
      p = '{0, 0, 0};
      for (int j = 2; j >= 0; j--) begin
        sin_cos(ang[j] * 16 + loff[j], ct, st);
        r[0][0] = ct; r[0][1] = -rnd(st * lca[j]); r[0][2] = rnd(st * lsa[j]);
        r[1][0] = st; r[1][1] = rnd(ct * lca[j]);  r[1][2] = -rnd(ct * lsa[j]);
        r[2][0] = 0;  r[2][1] = lsa[j];            r[2][2] = lca[j];
        t[0] = rnd(la[j] * ct);
        t[1] = rnd(la[j] * st);
        t[2] = ld[j];
        transform(r, t, p);
      end
      if (!arm_side) begin
        r = '{'{0, 0, -65536}, '{-65536, 0, 0}, '{0, 65536, 0}};
        t = '{-6184, -40, -4138};
      end else begin
        r = '{'{0, 0, 65536}, '{65536, 0, 0}, '{0, 65536, 0}};
        t = '{-6184, 40, -4138};
      end
      transform(r, t, p);
      e.x = clamp(p[0]);
      e.y = clamp(p[1]);
      e.z = clamp(p[2]);
      pending.insert(pending.size(), e);
    endfunction

    function void check_position(position_t got);
      position_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin
        $display("%0t: x_pos expected %0d actual %0d", $time, e.x, got.x);
        errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t: y_pos expected %0d actual %0d", $time, e.y, got.y);
        errors++;
      end
      if (got.z !== e.z) begin
        $display("%0t: z_pos expected %0d actual %0d", $time, e.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_first_angle = 0;
  logic signed [15:0] in_second_angle = 0;
  logic signed [15:0] in_third_angle = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [19:0] out_x_pos, out_y_pos, out_z_pos;

  position_scoreboard sb;
  bit gaps_on = 1;
  bit hold_request = 0;
  int idle_cycles = 0;

  dh_forward_kinematics_3dof_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_angle(in_first_angle), .in_second_angle(in_second_angle),
    .in_third_angle(in_third_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_pos(out_x_pos), .out_y_pos(out_y_pos), .out_z_pos(out_z_pos)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_position('{out_x_pos, out_y_pos, out_z_pos});
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("** dh_forward_kinematics_3dof_unit: FAILED **");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        hold_request = 0;
        out_stall <= 0;
        @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  task automatic send_angles(logic signed [15:0] a1, logic signed [15:0] a2,
                             logic signed [15:0] a3);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_first_angle <= a1;
    in_second_angle <= a2;
    in_third_angle <= a3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_angles(a1, a2, a3);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_side(bit side);
    cfg_we <= 1;
    cfg_wdata <= side;
    @(posedge clk);
    cfg_we <= 0;
    sb.arm_side = side;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 65535));
      default: return $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
    endcase
  endfunction

  initial begin
    logic signed [15:0] edge_vals[8];
    sb = new();
    edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
                  16'sd6434, -16'sd6434, 16'sd12868};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int side = 0; side < 2; side++) begin
      write_side(side);
      for (int i = 0; i < 8; i++)
        send_angles(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
      send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
      drain();
    end
    for (int ph = 0; ph < 4; ph++) begin
      write_side(ph[0]);
      if (ph == 1) hold_request = 1;
      if (ph == 3) gaps_on = 0;
      for (int i = 0; i < 400; i++)
        send_angles(pick_angle(), pick_angle(), pick_angle());
      drain();
    end
    if (sb.errors == 0)
      $display("** dh_forward_kinematics_3dof_unit: PASSED **");
    else
      $display("** dh_forward_kinematics_3dof_unit: FAILED **");
    $finish;
  end

endmodule
